// ----- design/gce_pkg.sv -----
package gce_pkg;

    localparam int MaxWidth = 32;
    localparam int RowW     = 32;
    localparam int WidthW   = 6;
    localparam int ModeW    = 2;
    localparam int ByteIdxW = 4;

    // coverage mode codes
    localparam logic [ModeW-1:0] ModeBits1 = 2'd0;
    localparam logic [ModeW-1:0] ModeBits2 = 2'd1;
    localparam logic [ModeW-1:0] ModeBits4 = 2'd2;

    // configuration register indexes
    localparam logic CfgGlyphWidth  = 1'b0;
    localparam logic CfgCoverageMode = 1'b1;

    localparam logic [WidthW-1:0] WidthReset = 6'd8;

    // one output row to emit: the pending row and its neighbors
    typedef struct packed {
        logic [RowW-1:0] up;
        logic [RowW-1:0] mid;
        logic [RowW-1:0] down;
        logic            final_row;
        logic            second;
    } t_job;

endpackage

// ----- design/gce_row_track.sv -----
module gce_row_track (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [gce_pkg::RowW-1:0] i_row_bits,
    input  logic                   i_last_row,
    output gce_pkg::t_job          o_job,
    output logic                   o_job_load
);

    logic [gce_pkg::RowW-1:0] r_above;
    logic [gce_pkg::RowW-1:0] r_centre;
    logic                     r_centre_valid;

    always_comb begin
        if (r_centre_valid) begin
            o_job.up        = r_above;
            o_job.mid       = r_centre;
            o_job.down      = i_row_bits;
            o_job.final_row = 1'b0;
        end else begin
            // single-row glyph: clear rows above and below
            o_job.up        = '0;
            o_job.mid       = i_row_bits;
            o_job.down      = '0;
            o_job.final_row = 1'b1;
        end
        o_job.second = r_centre_valid && i_last_row;
        o_job_load   = i_accept && (r_centre_valid || i_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above        <= '0;
            r_centre       <= '0;
            r_centre_valid <= 1'b0;
        end else if (i_accept) begin
            if (!i_last_row) begin
                r_above        <= r_centre_valid ? r_centre : '0;
                r_centre       <= i_row_bits;
                r_centre_valid <= 1'b1;
            end else begin
                r_above        <= '0;
                r_centre       <= '0;
                r_centre_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/gce_pixel_unit.sv -----
module gce_pixel_unit (
    input  logic [gce_pkg::RowW-1:0]     i_up,
    input  logic [gce_pkg::RowW-1:0]     i_mid,
    input  logic [gce_pkg::RowW-1:0]     i_down,
    input  logic [gce_pkg::WidthW-1:0]   i_width,
    input  logic [gce_pkg::ModeW-1:0]    i_mode,
    input  logic [gce_pkg::ByteIdxW-1:0] i_byte_idx,
    output logic [7:0]                   o_byte
);

    logic [gce_pkg::RowW-1:0] mask;
    logic [gce_pkg::RowW+1:0] ue;
    logic [gce_pkg::RowW+1:0] me;
    logic [gce_pkg::RowW+1:0] de;
    logic [3:0]               lv [gce_pkg::RowW];
    logic [gce_pkg::RowW-1:0] raw_shift;

    function automatic logic [3:0] level4(input logic [3:0] n);
        logic [7:0] t;
        t = 8'(n) * 8'd15 + 8'd4;
        if (t[7:3] > 5'd14) begin
            return 4'd14;
        end
        return t[6:3];
    endfunction

    always_comb begin
        logic [3:0] n;
        mask = ~({gce_pkg::RowW{1'b1}} >> i_width);
        // zero pad on both sides so edge columns see clear neighbors
        ue = {1'b0, i_up & mask, 1'b0};
        me = {1'b0, i_mid & mask, 1'b0};
        de = {1'b0, i_down & mask, 1'b0};
        for (int c = 0; c < gce_pkg::RowW; c++) begin
            n = 4'(ue[33-c]) + 4'(ue[32-c]) + 4'(ue[31-c])
              + 4'(de[33-c]) + 4'(de[32-c]) + 4'(de[31-c])
              + 4'(me[33-c]) + 4'(me[31-c]);
            if (me[32-c]) begin
                lv[c] = (i_mode == gce_pkg::ModeBits2) ? 4'd3 : 4'd15;
            end else if (n == 4'd0) begin
                lv[c] = 4'd0;
            end else if (i_mode == gce_pkg::ModeBits2) begin
                lv[c] = (n >= 4'd3) ? 4'd2 : 4'd1;
            end else begin
                lv[c] = level4(n);
            end
        end
    end

    always_comb begin
        logic [5:0] col;
        raw_shift = i_mid >> {~i_byte_idx[1:0], 3'b000};
        o_byte    = 8'd0;
        col       = 6'd0;
        case (i_mode)
            gce_pkg::ModeBits1: begin
                // raw bits pass through, not masked to the width
                o_byte = raw_shift[7:0];
            end
            gce_pkg::ModeBits2: begin
                for (int i = 0; i < 4; i++) begin
                    col = {i_byte_idx[3:0], 2'b00} + 6'(i);
                    if (col < i_width) begin
                        o_byte[7-2*i -: 2] = lv[col[4:0]][1:0];
                    end
                end
            end
            default: begin
                for (int i = 0; i < 2; i++) begin
                    col = {1'b0, i_byte_idx, 1'b0} + 6'(i);
                    if (col < i_width) begin
                        o_byte[7-4*i -: 4] = lv[col[4:0]];
                    end
                end
            end
        endcase
    end

endmodule

// ----- design/gce_emitter.sv -----
module gce_emitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gce_pkg::t_job              i_job,
    input  logic                       i_job_load,
    input  logic [gce_pkg::WidthW-1:0] i_glyph_width,
    input  logic [gce_pkg::ModeW-1:0]  i_coverage_mode,
    input  logic                       i_out_stall,
    output logic                       o_free,
    output logic                       o_out_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_row_end,
    output logic                       o_last_byte
);

    gce_pkg::t_job                r_job;
    logic                         r_busy;
    logic [gce_pkg::ByteIdxW-1:0] r_k;
    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic                         r_row_end;
    logic                         r_last_byte;

    logic [gce_pkg::WidthW-1:0]   width_eff;
    logic [7:0]                   bits_per_row;
    logic [7:0]                   bytes_sum;
    logic [4:0]                   nbytes;
    logic [gce_pkg::ByteIdxW-1:0] last_k;
    logic                         out_free;
    logic                         advance;
    logic                         at_end;
    logic [7:0]                   cur_byte;

    always_comb begin
        width_eff = (i_glyph_width > 6'(gce_pkg::MaxWidth))
                  ? 6'(gce_pkg::MaxWidth) : i_glyph_width;
        case (i_coverage_mode)
            gce_pkg::ModeBits1: bits_per_row = {2'b00, width_eff};
            gce_pkg::ModeBits2: bits_per_row = {1'b0, width_eff, 1'b0};
            default:            bits_per_row = {width_eff, 2'b00};
        endcase
        bytes_sum = bits_per_row + 8'd7;
        nbytes    = bytes_sum[7:3];
        // zero width still emits one byte
        last_k    = (nbytes == 5'd0) ? '0 : 4'(nbytes - 5'd1);
        out_free  = !r_out_valid || !i_out_stall;
        advance   = r_busy && out_free;
        at_end    = (r_k == last_k);
        o_free    = !r_busy || (advance && at_end && !r_job.second);
    end

    gce_pixel_unit u_pixel (
        .i_up       (r_job.up),
        .i_mid      (r_job.mid),
        .i_down     (r_job.down),
        .i_width    (width_eff),
        .i_mode     (i_coverage_mode),
        .i_byte_idx (r_k),
        .o_byte     (cur_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_job_load) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (advance && at_end) begin
            if (r_job.second) begin
                r_k <= '0;
            end else begin
                r_busy <= 1'b0;
            end
        end else if (advance) begin
            r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
        end else if (advance && at_end && r_job.second) begin
            // second row of the final step: shift the window down one row
            r_job.up        <= r_job.mid;
            r_job.mid       <= r_job.down;
            r_job.down      <= '0;
            r_job.final_row <= 1'b1;
            r_job.second    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte  <= cur_byte;
            r_row_end   <= at_end;
            r_last_byte <= at_end && r_job.final_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_row_end   = r_row_end;
    assign o_last_byte = r_last_byte;

endmodule

// ----- design/glyph_coverage_expander.sv -----
// glyph coverage expander
// input channel: one bitmap row per item (i_row_bits, column 0 at bit 31) with
// i_last_row marking the final row; accepted when i_in_valid is high and
// o_in_stall is low.
// output channel: one packed byte per item on o_out_byte, with o_row_end on the
// last byte of a row and o_last_byte on the last byte of the glyph; taken when
// o_out_valid is high and i_out_stall is low.
// the first row of a glyph gives no bytes unless it is also the final row; each
// later row releases the row before it, and the final row releases both
// remaining rows. a released row enters the emitter job register and its bytes
// then the output register. throughput: one byte per cycle while the receiver
// does not stall; a row gives max(1, (width*bpp+7)/8) bytes (up to 16), counted
// by the emitter byte counter, and a final row with a pending row gives twice
// that. the next row is accepted in the cycle the last byte of the current one
// moves into the output register. when the receiver stalls the output register
// holds and o_in_stall rises once the emitter has work queued. reset clears the
// row history and the emitter, and sets the glyph width to 8 and the mode to 1
// bit per pixel. the user makes configuration writes through i_cfg_wr_en,
// i_cfg_index, i_cfg_data only while idle; the block does not enforce this.
module glyph_coverage_expander (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [gce_pkg::RowW-1:0]     i_row_bits,
    input  logic                         i_last_row,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_row_end,
    output logic                         o_last_byte,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [gce_pkg::WidthW-1:0]   i_cfg_data
);

    logic [gce_pkg::WidthW-1:0] r_glyph_width;
    logic [gce_pkg::ModeW-1:0]  r_coverage_mode;

    gce_pkg::t_job job;
    logic          job_load;
    logic          free;
    logic          accept;

    assign o_in_stall = !free;
    assign accept     = i_in_valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width   <= gce_pkg::WidthReset;
            r_coverage_mode <= gce_pkg::ModeBits1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gce_pkg::CfgGlyphWidth:   r_glyph_width   <= i_cfg_data;
                gce_pkg::CfgCoverageMode: r_coverage_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    gce_row_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_row_bits (i_row_bits),
        .i_last_row (i_last_row),
        .o_job      (job),
        .o_job_load (job_load)
    );

    gce_emitter u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job),
        .i_job_load      (job_load),
        .i_glyph_width   (r_glyph_width),
        .i_coverage_mode (r_coverage_mode),
        .i_out_stall     (i_out_stall),
        .o_free          (free),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_row_end       (o_row_end),
        .o_last_byte     (o_last_byte)
    );

endmodule

// ----- tb/tb_glyph_coverage_expander.sv -----
module tb_glyph_coverage_expander;
    timeunit 1ns;
    timeprecision 1ps;

    // the block treats the unused mode code like 4-bit mode
    localparam logic [gce_pkg::ModeW-1:0] ModeBits4Alias = 2'd3;
    localparam int CycleLimit  = 1_000_000;
    localparam int DrainCycles = 8;
    localparam int SettleCycles = 40;
    localparam int RandomRows  = 250;

    typedef struct packed {
        logic [7:0] value;
        logic       row_end;
        logic       last_byte;
    } t_glyph_byte;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [gce_pkg::RowW-1:0]     i_row_bits;
    logic                         i_last_row;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [7:0]                   o_out_byte;
    logic                         o_row_end;
    logic                         o_last_byte;
    logic                         i_cfg_wr_en;
    logic                         i_cfg_index;
    logic [gce_pkg::WidthW-1:0]   i_cfg_data;

    glyph_coverage_expander u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_row_bits  (i_row_bits),
        .i_last_row  (i_last_row),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_row_end   (o_row_end),
        .o_last_byte (o_last_byte),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [gce_pkg::WidthW-1:0] cfg_width;
    logic [gce_pkg::ModeW-1:0]  cfg_mode;
    logic [gce_pkg::RowW-1:0]   hist_above;
    logic [gce_pkg::RowW-1:0]   hist_centre;
    logic                       hist_pending;

    t_glyph_byte expected_bytes[$];
    int fail_count;
    int cycle_count;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with its style redrawn at random from four
    initial begin
        int style;
        int phase;
        style = 0;
        phase = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 128 == 0) style = $urandom_range(0, 3);
            case (style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ((phase % 16) < 5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_glyph_byte got;
        t_glyph_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{value: o_out_byte, row_end: o_row_end, last_byte: o_last_byte};
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h row_end %0b last_byte %0b",
                         $time, got.value, got.row_end, got.last_byte);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (got.value !== want.value || got.row_end !== want.row_end ||
                    got.last_byte !== want.last_byte) begin
                    $display("%0t: mismatch expected %02h/%0b/%0b got %02h/%0b/%0b",
                             $time, want.value, want.row_end, want.last_byte,
                             got.value, got.row_end, got.last_byte);
                    fail_count++;
                end
            end
        end
    end

    function automatic int active_width();
        int w;
        w = int'(cfg_width);
        if (w > gce_pkg::MaxWidth) w = gce_pkg::MaxWidth;
        if (w > gce_pkg::RowW) w = gce_pkg::RowW;
        return w;
    endfunction

    function automatic int pixel(logic [gce_pkg::RowW-1:0] row, int col, int w);
        if (col < 0 || col >= w) return 0;
        return int'(row[gce_pkg::RowW-1-col]);
    endfunction

    function automatic int coverage_level(logic [gce_pkg::RowW-1:0] up,
                                          logic [gce_pkg::RowW-1:0] mid,
                                          logic [gce_pkg::RowW-1:0] down,
                                          int col, int w, int bpp);
        int n;
        int lv;
        if (pixel(mid, col, w) != 0) return (bpp == 2) ? 3 : 15;
        n = 0;
        for (int dx = -1; dx <= 1; dx++) begin
            n += pixel(up, col + dx, w) + pixel(down, col + dx, w);
            if (dx != 0) n += pixel(mid, col + dx, w);
        end
        if (n == 0) return 0;
        if (bpp == 2) return (n >= 3) ? 2 : 1;
        lv = (n * 15 + 4) / 8;
        if (lv < 1) lv = 1;
        if (lv > 14) lv = 14;
        return lv;
    endfunction

    task automatic expect_row(input logic [gce_pkg::RowW-1:0] up,
                              input logic [gce_pkg::RowW-1:0] mid,
                              input logic [gce_pkg::RowW-1:0] down, input bit is_last);
        int w;
        int bpp;
        int nbytes;
        int per;
        int col;
        logic [7:0] bval;
        t_glyph_byte item;
        w = active_width();
        bpp = (cfg_mode == gce_pkg::ModeBits1) ? 1 :
              ((cfg_mode == gce_pkg::ModeBits2) ? 2 : 4);
        nbytes = (w * bpp + 7) / 8;
        if (nbytes < 1) nbytes = 1;
        per = 8 / bpp;
        for (int k = 0; k < nbytes; k++) begin
            bval = '0;
            if (bpp == 1) begin
                bval = 8'(mid >> (24 - 8 * k));
            end else begin
                for (int i = 0; i < per; i++) begin
                    col = k * per + i;
                    if (col < w)
                        bval |= 8'(coverage_level(up, mid, down, col, w, bpp)
                                   << (8 - bpp - i * bpp));
                end
            end
            item.value = bval;
            item.row_end = (k + 1 == nbytes);
            item.last_byte = is_last && (k + 1 == nbytes);
            expected_bytes.insert(expected_bytes.size(), item);
        end
    endtask

    task automatic predict_row(input logic [gce_pkg::RowW-1:0] row, input bit is_last);
        if (!hist_pending) begin
            if (!is_last) begin
                hist_above = '0;
                hist_centre = row;
                hist_pending = 1'b1;
                return;
            end
            expect_row('0, row, '0, 1'b1);
        end else if (!is_last) begin
            expect_row(hist_above, hist_centre, row, 1'b0);
            hist_above = hist_centre;
            hist_centre = row;
            return;
        end else begin
            expect_row(hist_above, hist_centre, row, 1'b0);
            expect_row(hist_centre, row, '0, 1'b1);
        end
        hist_above = '0;
        hist_centre = '0;
        hist_pending = 1'b0;
    endtask

    // valid stays high after acceptance; idle_sender lowers it
    task automatic send_row(input logic [gce_pkg::RowW-1:0] row, input bit is_last);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_row_bits <= row;
        i_last_row <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_row(row, is_last);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            idle_sender(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drain();
        idle_sender(1);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_config(input int width, input logic [gce_pkg::ModeW-1:0] mode);
        wait_drain();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= gce_pkg::CfgGlyphWidth;
        i_cfg_data <= gce_pkg::WidthW'(width);
        @(negedge i_clk);
        i_cfg_index <= gce_pkg::CfgCoverageMode;
        i_cfg_data <= gce_pkg::WidthW'(mode);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width = gce_pkg::WidthW'(width);
        cfg_mode = mode;
    endtask

    function automatic logic [gce_pkg::RowW-1:0] random_row();
        case ($urandom_range(0, 6))
            0: return $urandom & $urandom & $urandom;
            1: return $urandom | $urandom;
            2: return '1;
            3: return '0;
            4: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_glyph(input int height);
        for (int r = 0; r < height; r++) begin
            send_row(random_row(), r == height - 1);
            pace_sender();
        end
    endtask

    // reset values: width 8, raw rows
    task automatic test_reset_defaults();
        send_row(32'hA5FF_0000, 1'b0);
        send_row(32'h5A00_00FF, 1'b1);
        idle_sender(3);
    endtask

    task automatic test_single_row();
        write_config(32, gce_pkg::ModeBits4);
        send_row(32'h8000_0001, 1'b1);
        write_config(32, gce_pkg::ModeBits2);
        send_row(32'hFFFF_FFFF, 1'b1);
    endtask

    // full rows around a clear one, and a clear pixel ringed by eight set ones
    task automatic test_neighbor_counts();
        logic [gce_pkg::ModeW-1:0] modes[2];
        modes[0] = gce_pkg::ModeBits4;
        modes[1] = gce_pkg::ModeBits2;
        foreach (modes[m]) begin
            write_config(32, modes[m]);
            send_row(32'hFFFF_FFFF, 1'b0);
            send_row(32'h0000_0000, 1'b0);
            send_row(32'hFFFF_FFFF, 1'b1);
            send_row(32'hE000_0007, 1'b0);
            send_row(32'hA000_0005, 1'b0);
            send_row(32'hE000_0007, 1'b1);
        end
    endtask

    task automatic test_width_limits();
        write_config(0, gce_pkg::ModeBits1);
        send_row(32'hC300_0000, 1'b1);
        write_config(0, gce_pkg::ModeBits2);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_config(63, gce_pkg::ModeBits4);
        send_row(32'h0F0F_0F0F, 1'b1);
        write_config(40, gce_pkg::ModeBits2);
        send_row(32'h8421_8421, 1'b1);
        write_config(1, gce_pkg::ModeBits4);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_config(5, ModeBits4Alias);
        send_row(32'h5000_0000, 1'b1);
        // bits past the width pass through in 1-bit mode
        write_config(3, gce_pkg::ModeBits1);
        send_row(32'hFFFF_FFFF, 1'b1);
    endtask

    // registers rewritten while a row is still pending
    task automatic test_midglyph_config();
        write_config(16, gce_pkg::ModeBits2);
        send_row(32'h1234_5678, 1'b0);
        write_config(12, gce_pkg::ModeBits4);
        send_row(32'hF0F0_F0F0, 1'b0);
        write_config(32, gce_pkg::ModeBits1);
        send_row(32'h0FF0_0FF0, 1'b1);
    endtask

    task automatic test_random_glyphs();
        int rows_sent;
        int glyphs;
        int height;
        int pick;
        rows_sent = 0;
        glyphs = 0;
        burst_left = 8;
        while (rows_sent < RandomRows) begin
            if (glyphs % 4 == 0) begin
                pick = $urandom_range(0, 19);
                write_config((pick == 0) ? 0 :
                             (pick == 1) ? $urandom_range(33, 63) :
                             (pick == 2) ? 32 :
                             (pick == 3) ? 1 : $urandom_range(1, 32),
                             gce_pkg::ModeW'($urandom_range(0, 3)));
            end
            height = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 8);
            send_glyph(height);
            rows_sent += height;
            glyphs++;
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    // sender holds off until the block has delivered everything
    task automatic test_drain_pause();
        write_config(24, gce_pkg::ModeBits4);
        send_row(32'hAAAA_AAAA, 1'b0);
        send_row(32'h5555_5555, 1'b0);
        wait_drain();
        send_row(32'hFFFF_0000, 1'b1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_row_bits = '0;
        i_last_row = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = gce_pkg::CfgGlyphWidth;
        i_cfg_data = '0;
        cfg_width = gce_pkg::WidthReset;
        cfg_mode = gce_pkg::ModeBits1;
        hist_above = '0;
        hist_centre = '0;
        hist_pending = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_single_row();
        test_neighbor_counts();
        test_width_limits();
        test_midglyph_config();
        test_drain_pause();
        test_random_glyphs();

        idle_sender(1);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
